/* hdl/rti_pkg.sv */
`timescale 1ns / 1ps

package rti_pkg;

   // Dot products and the divider work modulo 2^64.
   localparam int DOT_WIDTH    = 64;
   localparam int UV_FRAC      = 16;
   localparam int UV_WIDTH     = UV_FRAC + 1;
   localparam int THRESH_WIDTH = 20;
   localparam logic [THRESH_WIDTH-1:0] THRESH_RESET = 20'd168;

   typedef enum logic [1:0] {
      CSR_ORIGIN_X      = 2'd0,
      CSR_ORIGIN_Y      = 2'd1,
      CSR_ORIGIN_Z      = 2'd2,
      CSR_DET_THRESHOLD = 2'd3
   } csr_index_type;

   // One word on its way through the decision and divider stages.
   typedef struct packed {
      logic                 hit;
      logic [DOT_WIDTH-1:0] adet;
      logic [DOT_WIDTH-1:0] rem_u;
      logic [DOT_WIDTH-1:0] rem_v;
      logic [UV_WIDTH-1:0]  quo_u;
      logic [UV_WIDTH-1:0]  quo_v;
   } rti_lane_type;

endpackage

/* hdl/ray_triangle_intersect_top.sv */
`timescale 1ns / 1ps

// Moller-Trumbore ray/triangle test, fully pipelined. One word (three vertices
// and a ray direction, signed fixed point) can enter every cycle unless stalled;
// its result word (hit, barycentric u and v as unsigned Q1.16, truncated, zero
// on a miss) takes 3 stages for edges and cross products, 2 for the split dot
// products, 2 for the sign fold and miss tests, and 17 restoring
// divider steps whose last register is the output register. The whole pipe
// advances together; when a result is held by rsp_ready low every stage holds
// and req_ready drops in the same cycle. Ray origin and the determinant
// threshold (|det| in units of 2^-(3*frac bits)) are written through the csr
// port, which is always ready, and must only change while the pipe is empty.
// All arithmetic is exact modulo 2^64.
module ray_triangle_intersect_top #(
   parameter int COORD_WIDTH = 16
) (
   input  logic                             clock,
   input  logic                             reset,

   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  rti_pkg::csr_index_type           csr_index,
   input  logic [((COORD_WIDTH > rti_pkg::THRESH_WIDTH) ?
                  COORD_WIDTH : rti_pkg::THRESH_WIDTH)-1:0] csr_data,

   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic signed [COORD_WIDTH-1:0]    req_vertex0_x,
   input  logic signed [COORD_WIDTH-1:0]    req_vertex0_y,
   input  logic signed [COORD_WIDTH-1:0]    req_vertex0_z,
   input  logic signed [COORD_WIDTH-1:0]    req_vertex1_x,
   input  logic signed [COORD_WIDTH-1:0]    req_vertex1_y,
   input  logic signed [COORD_WIDTH-1:0]    req_vertex1_z,
   input  logic signed [COORD_WIDTH-1:0]    req_vertex2_x,
   input  logic signed [COORD_WIDTH-1:0]    req_vertex2_y,
   input  logic signed [COORD_WIDTH-1:0]    req_vertex2_z,
   input  logic signed [COORD_WIDTH-1:0]    req_ray_dir_x,
   input  logic signed [COORD_WIDTH-1:0]    req_ray_dir_y,
   input  logic signed [COORD_WIDTH-1:0]    req_ray_dir_z,

   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_hit,
   output logic [rti_pkg::UV_WIDTH-1:0]     rsp_bary_u,
   output logic [rti_pkg::UV_WIDTH-1:0]     rsp_bary_v
);
   import rti_pkg::*;

   logic                          en;
   logic signed [COORD_WIDTH-1:0] origin_ff [3];
   logic [THRESH_WIDTH-1:0]       thresh_ff;
   logic signed [COORD_WIDTH-1:0] vert [3][3];
   logic signed [COORD_WIDTH-1:0] dir  [3];

   logic                          fr_valid;
   logic signed [COORD_WIDTH:0]   fr_e1 [3], fr_e2 [3], fr_s [3], fr_d [3];
   logic [DOT_WIDTH-1:0]          fr_q [3], fr_r [3];
   logic                          dot_valid;
   logic [DOT_WIDTH-1:0]          dot_val [4];
   logic                          dec_valid;
   rti_lane_type                  dec_lane;
   logic                          div_valid;
   rti_lane_type                  div_lane;

   // Advance the whole pipe unless a finished word is waiting.
   assign en        = !rsp_valid || rsp_ready;
   assign req_ready = en;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_ff[0] <= '0;
         origin_ff[1] <= '0;
         origin_ff[2] <= '0;
         thresh_ff    <= THRESH_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_ORIGIN_X:      origin_ff[0] <= csr_data[COORD_WIDTH-1:0];
            CSR_ORIGIN_Y:      origin_ff[1] <= csr_data[COORD_WIDTH-1:0];
            CSR_ORIGIN_Z:      origin_ff[2] <= csr_data[COORD_WIDTH-1:0];
            CSR_DET_THRESHOLD: thresh_ff    <= csr_data[THRESH_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      vert[0][0] = req_vertex0_x;
      vert[0][1] = req_vertex0_y;
      vert[0][2] = req_vertex0_z;
      vert[1][0] = req_vertex1_x;
      vert[1][1] = req_vertex1_y;
      vert[1][2] = req_vertex1_z;
      vert[2][0] = req_vertex2_x;
      vert[2][1] = req_vertex2_y;
      vert[2][2] = req_vertex2_z;
      dir[0]     = req_ray_dir_x;
      dir[1]     = req_ray_dir_y;
      dir[2]     = req_ray_dir_z;
   end

   // Edges, origin offset and the two cross products.
   rti_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .vert      (vert),
      .dir       (dir),
      .org       (origin_ff),
      .out_valid (fr_valid),
      .e1_out    (fr_e1),
      .e2_out    (fr_e2),
      .s_out     (fr_s),
      .d_out     (fr_d),
      .q_out     (fr_q),
      .r_out     (fr_r)
   );

   // det, u, v and t numerators.
   rti_dot #(.COORD_WIDTH(COORD_WIDTH)) u_dot (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (fr_valid),
      .e1        (fr_e1),
      .e2        (fr_e2),
      .s         (fr_s),
      .d         (fr_d),
      .q         (fr_q),
      .r         (fr_r),
      .out_valid (dot_valid),
      .dot_out   (dot_val)
   );

   // Threshold, sign and range tests.
   rti_decide u_decide (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .thresh    (thresh_ff),
      .in_valid  (dot_valid),
      .dot_in    (dot_val),
      .out_valid (dec_valid),
      .out_lane  (dec_lane)
   );

   // u and v fractions; the last step is the output register.
   rti_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (dec_valid),
      .in_lane   (dec_lane),
      .out_valid (div_valid),
      .out_lane  (div_lane)
   );

   // Drop the quotients on a miss.
   assign rsp_valid  = div_valid;
   assign rsp_hit    = div_lane.hit;
   assign rsp_bary_u = div_lane.hit ? div_lane.quo_u : '0;
   assign rsp_bary_v = div_lane.hit ? div_lane.quo_v : '0;

`ifndef SYNTHESIS
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (!en && dec_valid) |=> (dec_valid && $stable(dec_lane)))
      else $error("decision stage changed during a stall");

   a_hit_nonzero_det: assert property (@(posedge clock) disable iff (reset)
      (dec_valid && dec_lane.hit) |-> (dec_lane.adet != '0))
      else $error("hit with zero determinant reaches the divider");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_hit)
         && $stable(rsp_bary_u) && $stable(rsp_bary_v)))
      else $error("result word changed while waiting");
`endif

endmodule

/* hdl/rti_front.sv */
`timescale 1ns / 1ps

module rti_front #(
   parameter int COORD_WIDTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_valid,
   input  logic signed [COORD_WIDTH-1:0] vert [3][3],
   input  logic signed [COORD_WIDTH-1:0] dir  [3],
   input  logic signed [COORD_WIDTH-1:0] org  [3],
   output logic                          out_valid,
   output logic signed [COORD_WIDTH:0]   e1_out [3],
   output logic signed [COORD_WIDTH:0]   e2_out [3],
   output logic signed [COORD_WIDTH:0]   s_out  [3],
   output logic signed [COORD_WIDTH:0]   d_out  [3],
   output logic [rti_pkg::DOT_WIDTH-1:0] q_out  [3],
   output logic [rti_pkg::DOT_WIDTH-1:0] r_out  [3]
);
   import rti_pkg::*;

   localparam int EW = COORD_WIDTH + 1;
   localparam int PW = 2 * EW;

   logic                 valid_a_ff, valid_b_ff, valid_c_ff;
   logic signed [EW-1:0] e1_a_ff [3], e2_a_ff [3], s_a_ff [3], d_a_ff [3];
   logic signed [EW-1:0] e1_b_ff [3], e2_b_ff [3], s_b_ff [3], d_b_ff [3];
   logic signed [EW-1:0] e1_c_ff [3], e2_c_ff [3], s_c_ff [3], d_c_ff [3];
   logic signed [EW-1:0] e1_in [3], e2_in [3], s_in [3], d_in [3];
   logic signed [PW-1:0] pq_pos_ff [3], pq_neg_ff [3], pr_pos_ff [3], pr_neg_ff [3];
   logic [DOT_WIDTH-1:0] q_in [3], r_in [3], q_ff [3], r_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
         valid_b_ff <= 1'b0;
         valid_c_ff <= 1'b0;
      end else if (en) begin
         valid_a_ff <= in_valid;
         valid_b_ff <= valid_a_ff;
         valid_c_ff <= valid_b_ff;
      end
   end

   for (genvar c = 0; c < 3; c++) begin : g_axis
      localparam int C1 = (c + 1) % 3;
      localparam int C2 = (c + 2) % 3;
      logic signed [PW:0] dq, dr;

      always_comb begin
         e1_in[c] = EW'(vert[1][c]) - EW'(vert[0][c]);
         e2_in[c] = EW'(vert[2][c]) - EW'(vert[0][c]);
         s_in[c]  = EW'(org[c]) - EW'(vert[0][c]);
         d_in[c]  = EW'(dir[c]);
      end

      // Cross product terms of q = d x e2 and r = s x e1 take the stage's
      // operands straight from the previous register.
      always_comb begin
         dq = (PW+1)'(pq_pos_ff[c]) - (PW+1)'(pq_neg_ff[c]);
         dr = (PW+1)'(pr_pos_ff[c]) - (PW+1)'(pr_neg_ff[c]);
         q_in[c] = DOT_WIDTH'(128'(dq));
         r_in[c] = DOT_WIDTH'(128'(dr));
      end

      always_ff @(posedge clock) begin
         if (en) begin
            e1_a_ff[c] <= e1_in[c];
            e2_a_ff[c] <= e2_in[c];
            s_a_ff[c]  <= s_in[c];
            d_a_ff[c]  <= d_in[c];

            pq_pos_ff[c] <= d_a_ff[C1] * e2_a_ff[C2];
            pq_neg_ff[c] <= d_a_ff[C2] * e2_a_ff[C1];
            pr_pos_ff[c] <= s_a_ff[C1] * e1_a_ff[C2];
            pr_neg_ff[c] <= s_a_ff[C2] * e1_a_ff[C1];
            e1_b_ff[c]   <= e1_a_ff[c];
            e2_b_ff[c]   <= e2_a_ff[c];
            s_b_ff[c]    <= s_a_ff[c];
            d_b_ff[c]    <= d_a_ff[c];

            q_ff[c]    <= q_in[c];
            r_ff[c]    <= r_in[c];
            e1_c_ff[c] <= e1_b_ff[c];
            e2_c_ff[c] <= e2_b_ff[c];
            s_c_ff[c]  <= s_b_ff[c];
            d_c_ff[c]  <= d_b_ff[c];
         end
      end

      assign e1_out[c] = e1_c_ff[c];
      assign e2_out[c] = e2_c_ff[c];
      assign s_out[c]  = s_c_ff[c];
      assign d_out[c]  = d_c_ff[c];
      assign q_out[c]  = q_ff[c];
      assign r_out[c]  = r_ff[c];
   end

   assign out_valid = valid_c_ff;

endmodule

/* hdl/rti_dot.sv */
`timescale 1ns / 1ps

module rti_dot #(
   parameter int COORD_WIDTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_valid,
   input  logic signed [COORD_WIDTH:0]   e1 [3],
   input  logic signed [COORD_WIDTH:0]   e2 [3],
   input  logic signed [COORD_WIDTH:0]   s  [3],
   input  logic signed [COORD_WIDTH:0]   d  [3],
   input  logic [rti_pkg::DOT_WIDTH-1:0] q  [3],
   input  logic [rti_pkg::DOT_WIDTH-1:0] r  [3],
   output logic                          out_valid,
   output logic [rti_pkg::DOT_WIDTH-1:0] dot_out [4]
);
   import rti_pkg::*;

   localparam int EW   = COORD_WIDTH + 1;
   localparam int HALF = DOT_WIDTH / 2;
   localparam int LW   = EW + HALF + 1;

   // Dots: 0 det = e1.q, 1 nu = s.q, 2 nv = d.r, 3 nt = e2.r
   logic signed [EW-1:0]      a_op [4][3];
   logic [DOT_WIDTH-1:0]      b_op [4][3];
   logic signed [LW-1:0]      lo_ff [4][3];
   logic [HALF-1:0]           hi_ff [4][3];
   logic [DOT_WIDTH-1:0]      sum_in [4];
   logic [DOT_WIDTH-1:0]      sum_ff [4];
   logic                      valid_d_ff, valid_e_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_d_ff <= 1'b0;
         valid_e_ff <= 1'b0;
      end else if (en) begin
         valid_d_ff <= in_valid;
         valid_e_ff <= valid_d_ff;
      end
   end

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         a_op[0][c] = e1[c];
         b_op[0][c] = q[c];
         a_op[1][c] = s[c];
         b_op[1][c] = q[c];
         a_op[2][c] = d[c];
         b_op[2][c] = r[c];
         a_op[3][c] = e2[c];
         b_op[3][c] = r[c];
      end
   end

   for (genvar k = 0; k < 4; k++) begin : g_dot
      logic [DOT_WIDTH-1:0] term [3];

      for (genvar c = 0; c < 3; c++) begin : g_term
         logic signed [LW-1:0]        lo_in;
         logic signed [EW+HALF-1:0]   hi_full;

         // Split the 64-bit operand: low half unsigned, high half needs
         // only the low 32 bits of its product.
         always_comb begin
            lo_in   = a_op[k][c] * $signed({1'b0, b_op[k][c][HALF-1:0]});
            hi_full = a_op[k][c] * $signed(b_op[k][c][DOT_WIDTH-1:HALF]);
         end

         always_ff @(posedge clock) begin
            if (en) begin
               lo_ff[k][c] <= lo_in;
               hi_ff[k][c] <= hi_full[HALF-1:0];
            end
         end

         assign term[c] = DOT_WIDTH'(128'(lo_ff[k][c])) + {hi_ff[k][c], {HALF{1'b0}}};
      end

      assign sum_in[k] = term[0] + term[1] + term[2];

      always_ff @(posedge clock) begin
         if (en) begin
            sum_ff[k] <= sum_in[k];
         end
      end

      assign dot_out[k] = sum_ff[k];
   end

   assign out_valid = valid_e_ff;

endmodule

/* hdl/rti_decide.sv */
`timescale 1ns / 1ps

module rti_decide (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             en,
   input  logic [rti_pkg::THRESH_WIDTH-1:0] thresh,
   input  logic                             in_valid,
   input  logic [rti_pkg::DOT_WIDTH-1:0]    dot_in [4],
   output logic                             out_valid,
   output rti_pkg::rti_lane_type            out_lane
);
   import rti_pkg::*;

   logic                 valid_f_ff, valid_g_ff;
   logic                 dneg;
   logic                 zero_ff;
   logic [DOT_WIDTH-1:0] sum_raw;
   logic [DOT_WIDTH-1:0] adet_in, nu_in, nv_in, nt_in, sum_in;
   logic [DOT_WIDTH-1:0] adet_ff, nu_ff, nv_ff, nt_ff, sum_ff;
   logic [DOT_WIDTH-1:0] slack;
   logic                 miss;
   rti_lane_type         lane_in, lane_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_f_ff <= 1'b0;
         valid_g_ff <= 1'b0;
      end else if (en) begin
         valid_f_ff <= in_valid;
         valid_g_ff <= valid_f_ff;
      end
   end

   // Fold the determinant sign into every numerator.
   always_comb begin
      dneg    = dot_in[0][DOT_WIDTH-1];
      sum_raw = dot_in[1] + dot_in[2];
      adet_in = dneg ? DOT_WIDTH'(0) - dot_in[0] : dot_in[0];
      nu_in   = dneg ? DOT_WIDTH'(0) - dot_in[1] : dot_in[1];
      nv_in   = dneg ? DOT_WIDTH'(0) - dot_in[2] : dot_in[2];
      nt_in   = dneg ? DOT_WIDTH'(0) - dot_in[3] : dot_in[3];
      sum_in  = dneg ? DOT_WIDTH'(0) - sum_raw : sum_raw;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         zero_ff <= (dot_in[0] == '0);
         adet_ff <= adet_in;
         nu_ff   <= nu_in;
         nv_ff   <= nv_in;
         nt_ff   <= nt_in;
         sum_ff  <= sum_in;
      end
   end

   always_comb begin
      slack = adet_ff - sum_ff;
      miss  = zero_ff || (adet_ff < DOT_WIDTH'(thresh)) || nu_ff[DOT_WIDTH-1]
           || nv_ff[DOT_WIDTH-1] || slack[DOT_WIDTH-1] || nt_ff[DOT_WIDTH-1];
      lane_in.hit   = !miss;
      lane_in.adet  = adet_ff;
      lane_in.rem_u = nu_ff;
      lane_in.rem_v = nv_ff;
      lane_in.quo_u = '0;
      lane_in.quo_v = '0;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lane_ff <= lane_in;
      end
   end

   assign out_valid = valid_g_ff;
   assign out_lane  = lane_ff;

endmodule

/* hdl/rti_div.sv */
`timescale 1ns / 1ps

module rti_div (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_valid,
   input  rti_pkg::rti_lane_type in_lane,
   output logic                  out_valid,
   output rti_pkg::rti_lane_type out_lane
);
   import rti_pkg::*;

   localparam int STEPS = UV_FRAC + 1;

   logic         valid_ff [STEPS];
   rti_lane_type lane_ff  [STEPS];

   // One restoring step on both quotients; the integer step does not shift.
   function automatic rti_lane_type div_step(input rti_lane_type cur, input logic shift);
      rti_lane_type nxt;
      nxt = cur;
      if (shift) begin
         nxt.rem_u = {cur.rem_u[DOT_WIDTH-2:0], 1'b0};
         nxt.rem_v = {cur.rem_v[DOT_WIDTH-2:0], 1'b0};
         nxt.quo_u = {cur.quo_u[UV_WIDTH-2:0], 1'b0};
         nxt.quo_v = {cur.quo_v[UV_WIDTH-2:0], 1'b0};
      end
      if (nxt.rem_u >= cur.adet) begin
         nxt.rem_u    = nxt.rem_u - cur.adet;
         nxt.quo_u[0] = 1'b1;
      end
      if (nxt.rem_v >= cur.adet) begin
         nxt.rem_v    = nxt.rem_v - cur.adet;
         nxt.quo_v[0] = 1'b1;
      end
      return nxt;
   endfunction

   for (genvar k = 0; k < STEPS; k++) begin : g_step
      logic         valid_in;
      rti_lane_type lane_in;

      if (k == 0) begin : g_first
         assign valid_in = in_valid;
         assign lane_in  = div_step(in_lane, 1'b0);
      end else begin : g_next
         assign valid_in = valid_ff[k-1];
         assign lane_in  = div_step(lane_ff[k-1], 1'b1);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= valid_in;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            lane_ff[k] <= lane_in;
         end
      end
   end

   assign out_valid = valid_ff[STEPS-1];
   assign out_lane  = lane_ff[STEPS-1];

endmodule

/* bench/tb_ray_triangle_intersect_top.sv */
`timescale 1ns / 1ps

module tb_ray_triangle_intersect_top;
   import rti_pkg::*;

   localparam int CW         = 16;
   localparam int CSR_W      = (CW > THRESH_WIDTH) ? CW : THRESH_WIDTH;
   localparam int PIPE_DRAIN = 40;      // whole pipe plus margin
   localparam int CYCLE_MAX  = 400000;
   localparam int N_RANDOM   = 930;
   localparam int N_PHASES   = 5;

   typedef logic signed [CW-1:0] coord_t;
   typedef logic [63:0] wide_t;
   typedef struct {
      wide_t x, y, z;
   } vec3_t;

   // Expected result word.
   typedef struct {
      logic                hit;
      logic [UV_WIDTH-1:0] u;
      logic [UV_WIDTH-1:0] v;
   } isect_t;

   // Directed row: 12 coordinates, plus a typed-in result where it is obvious.
   typedef struct {
      coord_t c[12];
      bit     fixed;
      isect_t res;
   } dir_row_t;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   csr_index_type       csr_index = CSR_ORIGIN_X;
   logic [CSR_W-1:0]    csr_data = '0;
   logic                req_valid = 1'b0;
   logic                req_ready;
   coord_t              cur_word[12];
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic                rsp_hit;
   logic [UV_WIDTH-1:0] rsp_bary_u;
   logic [UV_WIDTH-1:0] rsp_bary_v;

   // Typed-in expectation that travels with the word on the bus.
   bit                  cur_fixed = 1'b0;
   isect_t              cur_res;

   // Bench copy of the configuration registers.
   coord_t              org_x, org_y, org_z;
   logic [THRESH_WIDTH-1:0] thresh;

   isect_t              pending_q[$];
   int                  fail_count = 0;
   int                  cycle_count = 0;
   int                  accepted_count = 0;
   dir_row_t            dir_tab[$];

   initial begin
      foreach (cur_word[i]) cur_word[i] = '0;
      cur_res = '{hit: 1'b0, u: '0, v: '0};
   end

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   ray_triangle_intersect_top #(.COORD_WIDTH(CW)) i_dut (
      .clock         (clock),
      .reset         (reset),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_vertex0_x (cur_word[0]),
      .req_vertex0_y (cur_word[1]),
      .req_vertex0_z (cur_word[2]),
      .req_vertex1_x (cur_word[3]),
      .req_vertex1_y (cur_word[4]),
      .req_vertex1_z (cur_word[5]),
      .req_vertex2_x (cur_word[6]),
      .req_vertex2_y (cur_word[7]),
      .req_vertex2_z (cur_word[8]),
      .req_ray_dir_x (cur_word[9]),
      .req_ray_dir_y (cur_word[10]),
      .req_ray_dir_z (cur_word[11]),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_hit       (rsp_hit),
      .rsp_bary_u    (rsp_bary_u),
      .rsp_bary_v    (rsp_bary_v)
   );

   // ---------------------------------------------------------------------
   // Intersection predictor, all arithmetic modulo 2^64.
   // ---------------------------------------------------------------------
   function automatic wide_t widen(coord_t c);
      return {{(64-CW){c[CW-1]}}, c};
   endfunction

   function automatic vec3_t vec_sub(vec3_t a, vec3_t b);
      vec3_t r;
      r.x = a.x - b.x;
      r.y = a.y - b.y;
      r.z = a.z - b.z;
      return r;
   endfunction

   function automatic vec3_t vec_cross(vec3_t a, vec3_t b);
      vec3_t r;
      r.x = a.y * b.z - a.z * b.y;
      r.y = a.z * b.x - a.x * b.z;
      r.z = a.x * b.y - a.y * b.x;
      return r;
   endfunction

   function automatic wide_t vec_dot(vec3_t a, vec3_t b);
      return a.x * b.x + a.y * b.y + a.z * b.z;
   endfunction

   // floor(n * 2^16 / d) by restoring division, 0 <= n <= d.
   function automatic logic [UV_WIDTH-1:0] bary_quotient(wide_t n, wide_t d);
      logic [UV_WIDTH-1:0] q;
      wide_t               rem;
      q   = '0;
      rem = n;
      if (rem >= d) begin
         q   = UV_WIDTH'(1);
         rem = rem - d;
      end
      for (int i = 0; i < UV_FRAC; i++) begin
         rem = rem << 1;
         q   = q << 1;
         if (rem >= d) begin
            q[0] = 1'b1;
            rem  = rem - d;
         end
      end
      return q;
   endfunction

   function automatic isect_t predict_isect(coord_t w[12]);
      vec3_t  p0, p1, p2, dir, org, e1, e2, q, s, r;
      wide_t  det, adet, nu, nv, nt;
      logic   dneg;
      isect_t res;
      res = '{hit: 1'b0, u: '0, v: '0};
      p0  = '{widen(w[0]), widen(w[1]), widen(w[2])};
      p1  = '{widen(w[3]), widen(w[4]), widen(w[5])};
      p2  = '{widen(w[6]), widen(w[7]), widen(w[8])};
      dir = '{widen(w[9]), widen(w[10]), widen(w[11])};
      org = '{widen(org_x), widen(org_y), widen(org_z)};
      e1   = vec_sub(p1, p0);
      e2   = vec_sub(p2, p0);
      q    = vec_cross(dir, e2);
      det  = vec_dot(e1, q);
      dneg = det[63];
      adet = dneg ? -det : det;
      // near-parallel ray, or exactly parallel when the threshold is zero
      if (det == 0 || adet < {44'd0, thresh}) return res;
      s  = vec_sub(org, p0);
      nu = vec_dot(s, q);
      if (dneg) nu = -nu;
      if (nu[63]) return res;
      r  = vec_cross(s, e1);
      nv = vec_dot(dir, r);
      if (dneg) nv = -nv;
      if (nv[63]) return res;
      nt = adet - (nu + nv);
      if (nt[63]) return res;
      nt = vec_dot(e2, r);
      if (dneg) nt = -nt;
      if (nt[63]) return res;
      res.hit = 1'b1;
      res.u   = bary_quotient(nu, adet);
      res.v   = bary_quotient(nv, adet);
      return res;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("[%0t] mismatch %s: got %0d, want %0d", $time, what, got, want);
      fail_count++;
   endtask

   // ---------------------------------------------------------------------
   // Monitor: sample pre-edge values, so nothing depends on event order.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      isect_t want;
      cycle_count <= cycle_count + 1;
      if (!reset) begin
         if (req_valid && req_ready) begin
            // typed-in rows override the predictor
            pending_q.push_back(cur_fixed ? cur_res : predict_isect(cur_word));
            accepted_count <= accepted_count + 1;
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_q.size() == 0) begin
               $display("[%0t] result word with nothing pending", $time);
               fail_count++;
            end else begin
               want = pending_q.pop_front();
               if (rsp_hit !== want.hit) report_mismatch("hit", rsp_hit, want.hit);
               if (rsp_bary_u !== want.u) report_mismatch("bary_u", rsp_bary_u, want.u);
               if (rsp_bary_v !== want.v) report_mismatch("bary_v", rsp_bary_v, want.v);
            end
         end
         // track register writes after the prediction above has used the old values
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_ORIGIN_X:      org_x  = csr_data[CW-1:0];
               CSR_ORIGIN_Y:      org_y  = csr_data[CW-1:0];
               CSR_ORIGIN_Z:      org_z  = csr_data[CW-1:0];
               CSR_DET_THRESHOLD: thresh = csr_data[THRESH_WIDTH-1:0];
               default: ;
            endcase
         end
      end else begin
         org_x  = '0;
         org_y  = '0;
         org_z  = '0;
         thresh = THRESH_RESET;
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      if (cycle_count > CYCLE_MAX) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Receiver: random stalls, plus one long hold-off to back up the pipe.
   // ---------------------------------------------------------------------
   initial begin
      bit held;
      int mode;
      held = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (!held && accepted_count > 150) begin
            // hold off long enough for the pipe to fill and drop req_ready
            held = 1'b1;
            rsp_ready <= 1'b0;
            repeat (200) @(posedge clock);
         end
         mode = $urandom_range(0, 3);
         repeat ($urandom_range(1, 40)) begin
            case (mode)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= ($urandom_range(0, 3) != 0);
               2: rsp_ready <= 1'($urandom_range(0, 1));
               default: rsp_ready <= ($urandom_range(0, 4) == 0);
            endcase
            @(posedge clock);
         end
      end
   end

   // ---------------------------------------------------------------------
   // Sender
   // ---------------------------------------------------------------------
   // Offer one word; hold it until the handshake, leave valid high.
   task automatic send_word(coord_t w[12], bit fixed, isect_t res);
      req_valid <= 1'b1;
      foreach (cur_word[i]) cur_word[i] <= w[i];
      cur_fixed <= fixed;
      cur_res   <= res;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic idle_gap(int n);
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // Write one register once the pipe has drained.
   task automatic write_csr(csr_index_type idx, logic [CSR_W-1:0] data);
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_q.size() != 0) @(posedge clock);
      repeat (PIPE_DRAIN) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic coord_t rand_coord();
      return coord_t'($urandom());
   endfunction

   function automatic coord_t near(coord_t base, int spread);
      return coord_t'(int'(base) + $urandom_range(0, 2 * spread) - spread);
   endfunction

   // Mostly triangles straddling the ray; the rest full-range noise.
   task automatic make_random(output coord_t w[12]);
      int spread, k;
      coord_t o[3];
      o = '{org_x, org_y, org_z};
      if ($urandom_range(0, 4) == 0) begin
         foreach (w[i]) w[i] = rand_coord();
      end else begin
         spread = 1 << $urandom_range(4, 11);
         k = $urandom_range(1, 4);
         for (int a = 0; a < 3; a++) begin
            w[9 + a] = near(0, spread);
         end
         for (int a = 0; a < 3; a++) begin
            for (int vtx = 0; vtx < 3; vtx++) begin
               w[3 * vtx + a] = near(coord_t'(int'(o[a]) + k * int'(w[9 + a])), 2 * spread);
            end
         end
      end
   endtask

   function automatic dir_row_t mk_row(int v[12], bit fixed, isect_t res);
      dir_row_t r;
      foreach (v[i]) r.c[i] = coord_t'(v[i]);
      r.fixed = fixed;
      r.res   = res;
      return r;
   endfunction

   initial begin
      isect_t miss, at_v0, none;
      coord_t w[12];
      miss  = '{hit: 1'b0, u: '0, v: '0};
      at_v0 = '{hit: 1'b1, u: '0, v: '0};
      none  = miss;
      // all zero: degenerate, det is zero
      dir_tab.push_back(mk_row('{0,0,0, 0,0,0, 0,0,0, 0,0,0}, 1, miss));
      // origin on vertex 0, ray along +z: hit at u = v = t = 0
      dir_tab.push_back(mk_row('{0,0,0, 256,0,0, 0,256,0, 0,0,256}, 1, at_v0));
      // ray in the triangle plane: parallel
      dir_tab.push_back(mk_row('{0,0,256, 256,0,256, 0,256,256, 256,0,0}, 1, miss));
      // tiny triangle: |det| below the reset threshold
      dir_tab.push_back(mk_row('{0,0,256, 1,0,256, 0,1,256, 0,0,1}, 1, miss));
      // all max, all min: degenerate
      dir_tab.push_back(mk_row('{32767,32767,32767, 32767,32767,32767,
                                 32767,32767,32767, 32767,32767,32767}, 1, miss));
      dir_tab.push_back(mk_row('{-32768,-32768,-32768, -32768,-32768,-32768,
                                 -32768,-32768,-32768, -32768,-32768,-32768}, 1, miss));
      // extremes mixed: the wide products
      dir_tab.push_back(mk_row('{-32768,32767,-32768, 32767,-32768,32767,
                                 -32768,-32768,32767, 32767,32767,-32768}, 0, none));
      dir_tab.push_back(mk_row('{32767,-32768,0, -32768,0,32767,
                                 0,32767,-32768, -32768,32767,32767}, 0, none));
      // clean hit inside, both windings
      dir_tab.push_back(mk_row('{-256,-256,512, 512,-256,512, -256,512,512, 0,0,256}, 0, none));
      dir_tab.push_back(mk_row('{-256,-256,512, -256,512,512, 512,-256,512, 0,0,256}, 0, none));
      // u below zero, v below zero, u + v above one
      dir_tab.push_back(mk_row('{256,-256,512, 768,-256,512, 256,512,512, 0,0,256}, 0, none));
      dir_tab.push_back(mk_row('{-256,256,512, 512,256,512, -256,768,512, 0,0,256}, 0, none));
      dir_tab.push_back(mk_row('{-256,-256,512, 128,-256,512, -256,128,512, 0,0,256}, 0, none));
      // behind the origin: t below zero
      dir_tab.push_back(mk_row('{-256,-256,512, 512,-256,512, -256,512,512, 0,0,-256}, 0, none));
      // on the edge: u + v exactly one, and v exactly zero
      dir_tab.push_back(mk_row('{-256,-256,256, 256,-256,256, -256,256,256, 0,0,256}, 0, none));
      dir_tab.push_back(mk_row('{-256,0,256, 256,0,256, 0,256,256, 0,0,512}, 0, none));
      // oblique direction
      dir_tab.push_back(mk_row('{100,-300,700, 900,-50,650, -400,600,800, 37,-11,255}, 0, none));

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part, reset configuration
      foreach (dir_tab[i]) begin
         send_word(dir_tab[i].c, dir_tab[i].fixed, dir_tab[i].res);
         if ($urandom_range(0, 2) == 0) idle_gap($urandom_range(1, 3));
      end

      // random part over several register settings
      for (int phase = 0; phase < N_PHASES; phase++) begin
         case (phase)
            0: ;
            1: begin
               write_csr(CSR_ORIGIN_X, CSR_W'($urandom()));
               write_csr(CSR_ORIGIN_Y, CSR_W'($urandom()));
               write_csr(CSR_ORIGIN_Z, CSR_W'($urandom()));
               write_csr(CSR_DET_THRESHOLD, '0);
            end
            2: begin
               write_csr(CSR_ORIGIN_X, CSR_W'(16'h7fff));
               write_csr(CSR_ORIGIN_Y, CSR_W'(16'h8000));
               write_csr(CSR_ORIGIN_Z, CSR_W'(16'h7fff));
               write_csr(CSR_DET_THRESHOLD, {THRESH_WIDTH{1'b1}});
            end
            3: begin
               write_csr(CSR_ORIGIN_X, CSR_W'(16'h8000));
               write_csr(CSR_ORIGIN_Y, CSR_W'(16'h7fff));
               write_csr(CSR_ORIGIN_Z, CSR_W'(16'h8000));
               write_csr(CSR_DET_THRESHOLD, CSR_W'($urandom_range(1, 5000)));
            end
            default: begin
               write_csr(CSR_ORIGIN_X, '0);
               write_csr(CSR_ORIGIN_Y, CSR_W'($urandom_range(0, 1023)));
               write_csr(CSR_ORIGIN_Z, CSR_W'($urandom()));
               write_csr(CSR_DET_THRESHOLD, CSR_W'($urandom()));
            end
         endcase
         // bursts of random length with random gaps
         for (int n = 0; n < N_RANDOM / N_PHASES; ) begin
            int burst;
            burst = $urandom_range(1, 24);
            for (int b = 0; b < burst && n < N_RANDOM / N_PHASES; b++, n++) begin
               make_random(w);
               send_word(w, 1'b0, none);
            end
            if ($urandom_range(0, 3) != 0) idle_gap($urandom_range(1, 8));
         end
      end
      req_valid <= 1'b0;

      // drain
      @(posedge clock);
      while (pending_q.size() != 0) @(posedge clock);
      repeat (PIPE_DRAIN) @(posedge clock);
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
